### sv/frame_slot_store_scan_and_prove_macros.svh
// Assertion macros used by the controller of the frame slot scanner.
`ifndef FRAME_SLOT_STORE_SCAN_AND_PROVE_MACROS_SVH
`define FRAME_SLOT_STORE_SCAN_AND_PROVE_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define FSS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define FSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fss_pkg.sv
`timescale 1ns / 1ps
package fss_pkg;

    localparam int WIN_LEN = 10;
    localparam int SLOTS_DEF = 16;
    localparam int MAX_SCOPES_DEF = 64;

    localparam logic [7:0] OP_MOV = 8'hC7;
    localparam logic [7:0] MODRM_D8 = 8'h45;
    localparam logic [7:0] MODRM_D32 = 8'h85;

    localparam logic CFG_SEED = 1'b0;
    localparam logic CFG_SCOPE = 1'b1;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_RECORD,
        ST_FLUSH,
        ST_SCAN,
        ST_VERDICT,
        ST_CLEAR
    } fss_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic judge;
        logic emit;
        logic emit_final;
        logic record;
        logic shift;
        logic scan_start;
        logic scan_step;
        logic verdict;
        logic clear;
    } fss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic scan_done;
        logic out_busy;
    } fss_stat_t;

endpackage

### sv/fss_ctrl.sv
`timescale 1ns / 1ps
module fss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_last,
    output fss_pkg::fss_cmd_t cmd,
    input  fss_pkg::fss_stat_t stat
);
    import fss_pkg::*;
    `include "frame_slot_store_scan_and_prove_macros.svh"

    fss_state_t state_reg, state_next;
    logic last_reg, last_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg <= last_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        last_next = last_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    last_next = s_last;
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                // Judge the oldest position when the window is full or flushing.
                if (!last_reg && !stat.full) begin
                    state_next = ST_IDLE;
                end else if (!stat.out_busy) begin
                    cmd.judge = 1'b1;
                    state_next = ST_RECORD;
                end
            end
            ST_RECORD: begin
                if (stat.hit) begin
                    if (!stat.out_busy) begin
                        cmd.emit = 1'b1;
                        cmd.emit_final = !last_reg;
                        cmd.record = 1'b1;
                        state_next = ST_FLUSH;
                    end
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                cmd.shift = 1'b1;
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (stat.empty) begin
                    cmd.shift = 1'b0;
                    cmd.scan_start = 1'b1;
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_JUDGE;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_VERDICT;
                end
            end
            ST_VERDICT: begin
                if (!stat.out_busy) begin
                    cmd.verdict = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `FSS_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE, "early ready")
    `FSS_ASSERT_NEXT(a_load_judge, aclk, aresetn, cmd.load, state_reg == ST_JUDGE, "no judge")
    `FSS_ASSERT_IMP(a_emit, aclk, aresetn, cmd.emit || cmd.verdict, !stat.out_busy, "busy output")
endmodule

### sv/fss_dp.sv
`timescale 1ns / 1ps
module fss_dp #(
    parameter int SLOTS = fss_pkg::SLOTS_DEF,
    parameter int MAX_SCOPES = fss_pkg::MAX_SCOPES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fss_pkg::fss_cmd_t  cmd,
    output fss_pkg::fss_stat_t stat,
    input  logic [7:0]         s_data_byte,
    input  logic [31:0]        s_byte_address,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [31:0]        m_store_address,
    output logic [31:0]        m_end_address,
    output logic signed [31:0] m_displacement,
    output logic signed [31:0] m_immediate,
    output logic               m_found,
    output logic               m_overflowed,
    output logic               m_final_res
);
    import fss_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [31:0] seed_reg;
    logic [6:0]  scope_reg;
    logic [7:0]  win_reg [WIN_LEN];
    logic [31:0] base_reg;
    logic [3:0]  fill_reg;
    logic [31:0] key_reg [SLOTS];
    logic [SLOTS-1:0] vld_reg, fseed_reg, fscope_reg, fbad_reg;
    logic [CW-1:0] used_reg;
    logic ovf_reg;
    // Judged match.
    logic hit_reg;
    logic [3:0] len_reg;
    logic [31:0] disp_reg, imm_reg;
    // Verdict scan.
    logic [CW-1:0] idx_reg;
    logic [1:0] qual_reg;
    logic [31:0] win_key_reg;
    // Output register.
    logic o_valid_reg;

    // Window decode of the oldest position.
    logic is_d8, is_d32;
    logic [31:0] d8, d32, i8, i32;
    always_comb begin
        is_d8 = win_reg[0] == OP_MOV && win_reg[1] == MODRM_D8 && fill_reg >= 4'd7;
        is_d32 = win_reg[0] == OP_MOV && win_reg[1] == MODRM_D32 && fill_reg >= 4'd10;
        d8 = {{24{win_reg[2][7]}}, win_reg[2]};
        i8 = {win_reg[6], win_reg[5], win_reg[4], win_reg[3]};
        d32 = {win_reg[5], win_reg[4], win_reg[3], win_reg[2]};
        i32 = {win_reg[9], win_reg[8], win_reg[7], win_reg[6]};
    end

    // Classification and associative lookup.
    logic c_seed, c_scope, lk_hit;
    logic [SW-1:0] lk_idx;
    always_comb begin
        c_seed = imm_reg == seed_reg;
        c_scope = !c_seed && scope_reg != 7'd0 && imm_reg <= {25'd0, scope_reg - 7'd1};
        lk_hit = 1'b0;
        lk_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (vld_reg[i] && key_reg[i] == disp_reg) begin
                lk_hit = 1'b1;
                lk_idx = SW'(i);
            end
        end
    end

    logic [CW-1:0] idx_cur;
    assign idx_cur = idx_reg;
    logic q_ok;
    assign q_ok = vld_reg[idx_cur[SW-1:0]] && fseed_reg[idx_cur[SW-1:0]]
                  && fscope_reg[idx_cur[SW-1:0]] && !fbad_reg[idx_cur[SW-1:0]];

    always_comb begin
        stat.full = fill_reg == 4'(WIN_LEN);
        stat.empty = fill_reg == 4'd0;
        stat.hit = hit_reg;
        stat.scan_done = idx_reg == CW'(SLOTS - 1);
        stat.out_busy = o_valid_reg && !m_ready;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '1;
            scope_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_SEED) seed_reg <= cfg_data;
            else scope_reg <= cfg_data[6:0];
        end
    end

    // Byte window.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            fill_reg <= '0;
            base_reg <= '0;
            for (int i = 0; i < WIN_LEN; i++) win_reg[i] <= '0;
        end else if (cmd.load) begin
            if (fill_reg == 4'd0) base_reg <= s_byte_address;
            win_reg[fill_reg] <= s_data_byte;
            fill_reg <= fill_reg + 4'd1;
        end else if (cmd.shift) begin
            for (int i = 0; i < WIN_LEN - 1; i++) win_reg[i] <= win_reg[i+1];
            win_reg[WIN_LEN-1] <= '0;
            fill_reg <= fill_reg - 4'd1;
            base_reg <= base_reg + 32'd1;
        end
    end

    // Judge stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (cmd.judge) begin
            hit_reg <= is_d8 || is_d32;
            len_reg <= is_d8 ? 4'd7 : 4'd10;
            disp_reg <= is_d8 ? d8 : d32;
            imm_reg <= is_d8 ? i8 : i32;
        end
    end

    // Slot table.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            vld_reg <= '0;
            fseed_reg <= '0;
            fscope_reg <= '0;
            fbad_reg <= '0;
            used_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.record && disp_reg[31]) begin
            if (lk_hit) begin
                fseed_reg[lk_idx] <= fseed_reg[lk_idx] | c_seed;
                fscope_reg[lk_idx] <= fscope_reg[lk_idx] | c_scope;
                fbad_reg[lk_idx] <= fbad_reg[lk_idx] | (!c_seed && !c_scope);
            end else if (used_reg < CW'(SLOTS)) begin
                key_reg[used_reg[SW-1:0]] <= disp_reg;
                vld_reg[used_reg[SW-1:0]] <= 1'b1;
                fseed_reg[used_reg[SW-1:0]] <= c_seed;
                fscope_reg[used_reg[SW-1:0]] <= c_scope;
                fbad_reg[used_reg[SW-1:0]] <= !c_seed && !c_scope;
                used_reg <= used_reg + CW'(1);
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Verdict scan, one slot a cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.scan_start) begin
            idx_reg <= '0;
            qual_reg <= '0;
            win_key_reg <= '0;
        end else if (cmd.scan_step) begin
            if (q_ok) begin
                qual_reg <= (qual_reg == 2'd0) ? 2'd1 : 2'd2;
                win_key_reg <= key_reg[idx_cur[SW-1:0]];
            end
            if (!stat.scan_done) idx_reg <= idx_reg + CW'(1);
        end
    end

    // Output register.
    logic ok;
    assign ok = scope_reg != 7'd0 && {25'd0, scope_reg} <= 32'(MAX_SCOPES)
                && !ovf_reg && qual_reg == 2'd1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.verdict) begin
            o_valid_reg <= 1'b1;
        end else if (m_ready) begin
            o_valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_kind <= KIND_MATCH;
            m_store_address <= base_reg;
            m_end_address <= base_reg + {28'd0, len_reg};
            m_displacement <= disp_reg;
            m_immediate <= imm_reg;
            m_found <= 1'b0;
            m_overflowed <= 1'b0;
            m_final_res <= cmd.emit_final;
        end else if (cmd.verdict) begin
            m_kind <= KIND_VERDICT;
            m_store_address <= '0;
            m_end_address <= '0;
            m_displacement <= ok ? win_key_reg : 32'd0;
            m_immediate <= '0;
            m_found <= ok;
            m_overflowed <= ovf_reg;
            m_final_res <= 1'b1;
        end
    end
    assign m_valid = o_valid_reg;
endmodule

### sv/frame_slot_store_scan_and_prove.sv
`timescale 1ns / 1ps
// A byte is taken only in the idle state, so the next byte waits until the last is through; a store
// is judged when its opcode byte is oldest in a full window and is emitted in the record state.
// The last byte judges each window position plus one empty round (judge, record, flush; up to 11),
// walks the slot table one entry a cycle, then gives the verdict (held while the output is busy) and clears.
// In a steady stream each byte passes load, judge, record and shift before the next, plus stalls.
// Reset: aresetn synchronous, active low; clears window, slot flags, seed to -1, scope_count to 0.
module frame_slot_store_scan_and_prove #(
    parameter int SLOTS = fss_pkg::SLOTS_DEF,
    parameter int MAX_SCOPES = fss_pkg::MAX_SCOPES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic [31:0]        s_byte_address,
    input  logic               s_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [31:0]        m_store_address,
    output logic [31:0]        m_end_address,
    output logic signed [31:0] m_displacement,
    output logic signed [31:0] m_immediate,
    output logic               m_found,
    output logic               m_overflowed,
    output logic               m_final_res
);
    import fss_pkg::*;

    fss_cmd_t cmd;
    fss_stat_t stat;

    assign cfg_ready = 1'b1;

    fss_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_last(s_last), .cmd(cmd), .stat(stat)
    );

    fss_dp #(.SLOTS(SLOTS), .MAX_SCOPES(MAX_SCOPES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_data_byte(s_data_byte), .s_byte_address(s_byte_address),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_store_address(m_store_address), .m_end_address(m_end_address),
        .m_displacement(m_displacement), .m_immediate(m_immediate),
        .m_found(m_found), .m_overflowed(m_overflowed), .m_final_res(m_final_res)
    );
endmodule

### verif/frame_slot_store_scan_and_prove_checker.sv
`timescale 1ns / 1ps
module frame_slot_store_scan_and_prove_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic [31:0]        s_byte_address,
    input  logic               s_last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_kind,
    input  logic [31:0]        m_store_address,
    input  logic [31:0]        m_end_address,
    input  logic signed [31:0] m_displacement,
    input  logic signed [31:0] m_immediate,
    input  logic               m_found,
    input  logic               m_overflowed,
    input  logic               m_final_res,
    output int                 fail_count,
    output int                 pending_count
);
    import fss_pkg::*;

    localparam int NSLOT = 16;
    localparam int MAXSC = 64;

    typedef struct packed {
        logic        kind;
        logic [31:0] store_addr;
        logic [31:0] end_addr;
        logic [31:0] disp;
        logic [31:0] imm;
        logic        found;
        logic        ovf;
        logic        fin;
    } scan_result_t;

    scan_result_t expected_results[$];

    // Mirror of the block's registers and scanning state.
    logic [31:0] seed_reg;
    logic [6:0]  scope_reg;
    logic [7:0]  win[WIN_LEN];
    logic [31:0] win_base;
    int          win_fill;
    logic [31:0] key_tab[NSLOT];
    logic        key_valid[NSLOT];
    logic        key_seed[NSLOT];
    logic        key_scope[NSLOT];
    logic        key_bad[NSLOT];
    int          keys_used;
    logic        tab_full;

    assign pending_count = expected_results.size();

    function automatic logic [31:0] word_at(int p);
        return {win[p + 3], win[p + 2], win[p + 1], win[p]};
    endfunction

    function automatic void clear_scan();
        for (int i = 0; i < WIN_LEN; i++) win[i] = '0;
        for (int i = 0; i < NSLOT; i++) begin
            key_valid[i] = 1'b0; key_seed[i] = 1'b0; key_scope[i] = 1'b0; key_bad[i] = 1'b0;
        end
        win_fill = 0;
        win_base = '0;
        keys_used = 0;
        tab_full = 1'b0;
    endfunction

    // Classify a store into its frame slot; non-negative slots are ignored.
    function automatic void note_slot(logic [31:0] disp, logic [31:0] imm);
        int cls;
        if (!disp[31]) return;
        if (imm == seed_reg) cls = 0;
        else if (scope_reg != 0 && imm <= {25'd0, scope_reg} - 1) cls = 1;
        else cls = 2;
        for (int i = 0; i < NSLOT; i++) begin
            if (key_valid[i] && key_tab[i] == disp) begin
                if (cls == 0) key_seed[i] = 1'b1;
                else if (cls == 1) key_scope[i] = 1'b1;
                else key_bad[i] = 1'b1;
                return;
            end
        end
        if (keys_used < NSLOT) begin
            key_tab[keys_used] = disp;
            key_valid[keys_used] = 1'b1;
            key_seed[keys_used] = (cls == 0);
            key_scope[keys_used] = (cls == 1);
            key_bad[keys_used] = (cls == 2);
            keys_used++;
        end else begin
            tab_full = 1'b1;
        end
    endfunction

    // Decide whether a store starts at window position p with `left` bytes available.
    function automatic void judge_position(int p, int left);
        scan_result_t r;
        int len;
        r = '0;
        if (win[p] != OP_MOV || left < 7) return;
        if (win[p + 1] == MODRM_D8) begin
            r.disp = {{24{win[p + 2][7]}}, win[p + 2]};
            r.imm = word_at(p + 3);
            len = 7;
        end else if (win[p + 1] == MODRM_D32 && left >= 10) begin
            r.disp = word_at(p + 2);
            r.imm = word_at(p + 6);
            len = 10;
        end else begin
            return;
        end
        r.kind = KIND_MATCH;
        r.store_addr = win_base + p;
        r.end_addr = win_base + p + len;
        expected_results = {expected_results, r};
        note_slot(r.disp, r.imm);
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic [31:0] addr, logic lst);
        int prior_count;
        int qual;
        logic [31:0] winner;
        scan_result_t v;
        prior_count = expected_results.size();
        if (win_fill == 0) win_base = addr;
        if (win_fill >= WIN_LEN) win_fill = WIN_LEN - 1;
        win[win_fill] = b;
        win_fill++;
        if (!lst) begin
            if (win_fill == WIN_LEN) begin
                judge_position(0, WIN_LEN);
                for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i + 1];
                win[WIN_LEN - 1] = '0;
                win_fill--;
                win_base++;
            end
        end else begin
            for (int p = 0; p < win_fill; p++) judge_position(p, win_fill - p);
            qual = 0;
            winner = '0;
            for (int i = 0; i < NSLOT; i++) begin
                if (key_valid[i] && key_seed[i] && key_scope[i] && !key_bad[i]) begin
                    qual++;
                    winner = key_tab[i];
                end
            end
            v = '0;
            v.kind = KIND_VERDICT;
            v.found = scope_reg != 0 && scope_reg <= MAXSC && !tab_full && qual == 1;
            v.disp = v.found ? winner : '0;
            v.ovf = tab_full;
            expected_results = {expected_results, v};
            clear_scan();
        end
        if (expected_results.size() > prior_count)
            expected_results[expected_results.size() - 1].fin = 1'b1;
    endfunction

    // Watch the three channels at each clock edge.
    always @(posedge aclk) begin
        scan_result_t e;
        scan_result_t a;
        if (!aresetn) begin
            seed_reg <= 32'hFFFF_FFFF;
            scope_reg <= '0;
            clear_scan();
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SEED) seed_reg <= cfg_data;
                else scope_reg <= cfg_data[6:0];
            end
            if (s_valid && s_ready) predict_byte(s_data_byte, s_byte_address, s_last);
            if (m_valid && m_ready) begin
                a = {m_kind, m_store_address, m_end_address, m_displacement, m_immediate,
                     m_found, m_overflowed, m_final_res};
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $realtime, a);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e !== a) begin
                        $display("%0t: mismatch kind %0d/%0d sa %h/%h ea %h/%h",
                                 $realtime, e.kind, a.kind, e.store_addr, a.store_addr,
                                 e.end_addr, a.end_addr);
                        $display("%0t:   disp %h/%h imm %h/%h fnd %0d/%0d ovf %0d/%0d fin %0d/%0d",
                                 $realtime, e.disp, a.disp, e.imm, a.imm, e.found, a.found,
                                 e.ovf, a.ovf, e.fin, a.fin);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### verif/frame_slot_store_scan_and_prove_test.sv
`timescale 1ns / 1ps
module frame_slot_store_scan_and_prove_test;
    import fss_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_data_byte;
    logic [31:0]        s_byte_address;
    logic               s_last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [31:0]        cfg_data;
    logic               m_valid;
    logic               m_ready;
    logic               m_kind;
    logic [31:0]        m_store_address;
    logic [31:0]        m_end_address;
    logic signed [31:0] m_displacement;
    logic signed [31:0] m_immediate;
    logic               m_found;
    logic               m_overflowed;
    logic               m_final_res;
    int                 fail_count;
    int                 pending_count;
    int                 cycle_count;
    logic               calm;
    logic               hold_off;
    logic               hold_go;

    frame_slot_store_scan_and_prove dut (.*);

    frame_slot_store_scan_and_prove_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else if (hold_off) m_ready <= 0;
        else m_ready <= calm || ($urandom_range(99) >= 17);
    end

    int          hold_cycles;
    initial begin
        hold_off = 0;
        wait (hold_go);
        @(posedge aclk);
        hold_off <= 1;
        for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(posedge aclk);
        hold_off <= 0;
    end

    logic [31:0] next_addr;

    // Offer one byte and wait until the block takes it.
    task automatic send_byte(logic [7:0] b, logic lst);
        while (!calm && $urandom_range(99) < 17) @(posedge aclk);
        s_valid <= 1;
        s_data_byte <= b;
        s_byte_address <= next_addr;
        s_last <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 0;
        next_addr = lst ? $urandom : next_addr + 1;
        // The block is busy after each transaction.
        @(posedge aclk);
    endtask

    task automatic send_word(logic [31:0] w);
        for (int i = 0; i < 4; i++) send_byte(w[8 * i +: 8], 1'b0);
    endtask

    // Emit a mov store, short or long form.
    task automatic send_store(logic long_form, logic [31:0] disp, logic [31:0] imm);
        send_byte(OP_MOV, 1'b0);
        if (long_form) begin
            send_byte(MODRM_D32, 1'b0);
            send_word(disp);
        end else begin
            send_byte(MODRM_D8, 1'b0);
            send_byte(disp[7:0], 1'b0);
        end
        send_word(imm);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // Let every expected result drain, the verdict included, then idle before the next test.
    task automatic settle();
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    logic [31:0] seed_val;
    logic [6:0]  scope_val;
    logic [31:0] slot_pool[4];
    int          ranges;

    // Pick a store value from seed, scope levels or noise.
    function automatic logic [31:0] pick_imm();
        int r;
        r = $urandom_range(9);
        if (r < 3) return seed_val;
        if (r < 7) return (scope_val == 0) ? 0 : $urandom_range(scope_val - 1);
        return $urandom;
    endfunction

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_data_byte = 0;
        s_byte_address = 0;
        s_last = 0;
        cfg_valid = 0;
        cfg_index = CFG_SEED;
        cfg_data = 0;
        calm = 0;
        hold_go = 0;
        next_addr = 32'hFFFF_FFFA;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset registers, empty scope count, address wrap.
        send_store(1'b0, 32'hFFFF_FFF8, 32'hFFFF_FFFF);
        send_store(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_byte(8'h00, 1'b1);
        settle();

        seed_val = 32'h8000_0000;
        scope_val = 7'd64;
        write_reg(CFG_SEED, seed_val);
        write_reg(CFG_SCOPE, {25'd0, scope_val});
        // One proven slot, positive displacement ignored, short form at range end.
        send_store(1'b0, 32'hFFFF_FFF0, seed_val);
        send_store(1'b0, 32'h0000_0010, 32'd5);
        send_store(1'b1, 32'hFFFF_FFF0, 32'd63);
        send_byte(OP_MOV, 1'b0);
        send_byte(MODRM_D8, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_word(32'd0);
        send_byte(OP_MOV, 1'b1);
        settle();

        // Two qualifying slots, then a byte-only range with last.
        send_store(1'b0, 32'hFFFF_FF80, seed_val);
        send_store(1'b0, 32'hFFFF_FF80, 32'd1);
        send_store(1'b1, 32'hFFFF_FF00, seed_val);
        send_store(1'b1, 32'hFFFF_FF00, 32'd2);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hC7, 1'b1);
        settle();

        // Table overflow with scope count above the limit, under a long receiver hold-off.
        write_reg(CFG_SCOPE, 32'd127);
        scope_val = 7'd127;
        hold_go = 1;
        for (int i = 0; i < 17; i++) send_store(1'b0, 32'hFFFF_FF80 + i, seed_val);
        send_byte(8'h00, 1'b1);
        settle();

        // Random ranges under several settings.
        calm = 1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin seed_val = 32'h7FFF_FFFF; scope_val = 7'd1; end
                1: begin seed_val = $urandom; scope_val = 7'd65; end
                2: begin seed_val = 32'd3; scope_val = 7'($urandom_range(1, 64)); end
                default: begin seed_val = $urandom_range(1, 4); scope_val = 7'd8; end
            endcase
            if (phase == 1) calm = 0;
            write_reg(CFG_SEED, seed_val);
            write_reg(CFG_SCOPE, {25'd0, scope_val});
            for (ranges = 0; ranges < 2; ranges++) begin
                for (int i = 0; i < 4; i++)
                    slot_pool[i] = 32'h8000_0000 | $urandom | ($urandom_range(1) ? 0 : 32'hFFFF_FF80);
                for (int k = 0; k < 2; k++) begin
                    case ($urandom_range(5))
                        0: send_byte(8'($urandom), 1'b0);
                        1: send_byte(OP_MOV, 1'b0);
                        2: send_store(1'($urandom_range(1)), $urandom, $urandom);
                        default: send_store(1'($urandom_range(1)), slot_pool[$urandom_range(3)],
                                            pick_imm());
                    endcase
                end
                send_byte($urandom_range(1) ? OP_MOV : 8'($urandom), 1'b1);
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
